// ===== rtl/sbdec_pkg.sv =====
package sbdec_pkg;

   // Field widths of the channels
   localparam int VALUE_BITS          = 64;
   localparam int CHAR_BITS           = 6;
   localparam int VALUE_WIDTH_DEFAULT = 64;

   // Character codes, truncated to the six bits the channel carries
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

   // Shift-add-3 correction
   localparam logic [3:0] BCD_ADJUST_MIN = 4'd5;
   localparam logic [3:0] BCD_ADJUST     = 4'd3;

   typedef struct packed {
      logic load;      // capture a new value
      logic step;      // one shift-add-3 iteration
      logic shift;     // drop the leading digit
      logic sel_sign;  // present the minus sign
   } cmd_type;

   typedef struct packed {
      logic convert_done;
      logic top_zero;
      logic last_digit;
      logic neg;
   } status_type;

endpackage

// ===== rtl/sbdec_req_if.sv =====
interface sbdec_req_if;
   import sbdec_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/sbdec_rsp_if.sv =====
interface sbdec_rsp_if;
   import sbdec_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] ascii_char;
   logic                 last_char;

   modport source (output valid, output ascii_char, output last_char, input ready);
   modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

// ===== rtl/sbdec_ctrl.sv =====
module sbdec_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sbdec_pkg::status_type status,
   output sbdec_pkg::cmd_type    cmd
);
   import sbdec_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_TRIM  = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_DIGIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (status.convert_done) begin
               state_in = ST_TRIM;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_TRIM: begin
            // drop leading zeros, keep at least one digit
            if (status.top_zero && !status.last_digit) begin
               cmd.shift = 1'b1;
            end else if (status.neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.sel_sign = 1'b1;
            if (rsp_ready) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.shift = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/sbdec_dpath.sv =====
module sbdec_dpath #(
   parameter int VALUE_WIDTH = sbdec_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic signed [sbdec_pkg::VALUE_BITS-1:0] req_value,
   input  sbdec_pkg::cmd_type                    cmd,
   output sbdec_pkg::status_type                 status,
   output logic [sbdec_pkg::CHAR_BITS-1:0]       rsp_ascii_char,
   output logic                                  rsp_last_char
);
   import sbdec_pkg::*;

   // Digits of 2^VALUE_WIDTH: floor(W * log10(2)) + 1, with log10(2) ~ 1233/4096
   localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
   localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [CNT_W-1:0]       bits_ff, bits_in;
   logic [DCNT_W-1:0]      digits_ff, digits_in;
   logic [VALUE_WIDTH-1:0] raw;
   logic [3:0]             top_digit;

   assign raw = req_value[VALUE_WIDTH-1:0];

   // add 3 to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= BCD_ADJUST_MIN) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + BCD_ADJUST;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      bcd_in    = bcd_ff;
      bits_in   = bits_ff;
      digits_in = digits_ff;
      if (cmd.load) begin
         neg_in    = raw[VALUE_WIDTH-1];
         mag_in    = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
         bcd_in    = '0;
         bits_in   = CNT_W'(VALUE_WIDTH);
         digits_in = DCNT_W'(NUM_DIGITS);
      end else if (cmd.step) begin
         bcd_in  = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in  = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bits_in = bits_ff - 1'b1;
      end else if (cmd.shift) begin
         bcd_in    = {bcd_ff[BCD_W-5:0], 4'b0000};
         digits_in = digits_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      bcd_ff    <= bcd_in;
      bits_ff   <= bits_in;
      digits_ff <= digits_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   assign status.convert_done = (bits_ff == '0);
   assign status.top_zero     = (top_digit == 4'd0);
   assign status.last_digit   = (digits_ff == DCNT_W'(1));
   assign status.neg          = neg_ff;

   assign rsp_ascii_char = cmd.sel_sign ? CHAR_MINUS
                                        : (CHAR_ZERO + {{(CHAR_BITS-4){1'b0}}, top_digit});
   assign rsp_last_char  = !cmd.sel_sign && status.last_digit;

endmodule

// ===== rtl/signed_binary_to_decimal_ascii.sv =====
// Signed binary to decimal ASCII. Each transfer on req carries one two's
// complement number; only its low VALUE_WIDTH bits count, and bit
// VALUE_WIDTH-1 is the sign. The block answers with its decimal text on
// rsp, one ASCII character per transfer, most significant digit first:
// a minus sign first for a negative number, then the digits of the
// magnitude without leading zeros, and last_char high on the final
// character. Zero gives the single character '0', and the most negative
// value prints its full magnitude. One number is handled at a time: req
// is ready only while the block is idle. An item goes through a load,
// VALUE_WIDTH shift-add-3 steps in the binary-to-BCD converter, a check
// that the conversion has finished, the trimming of leading zero digits
// and the pick of the sign or the first digit, and then one character
// per cycle sent while rsp is ready. Trimmed zeros and digits always add
// up to the width of the BCD register, 20 digits for 64-bit values.
// Nothing is kept from one number to the next.
module signed_binary_to_decimal_ascii #(
   parameter int VALUE_WIDTH = sbdec_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   sbdec_req_if.sink   req,
   sbdec_rsp_if.source rsp
);
   import sbdec_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: load, convert, trim leading zeros, send sign and digits
   sbdec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // magnitude, BCD digit register and counters
   sbdec_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .req_value      (req.value),
      .cmd            (cmd),
      .status         (status),
      .rsp_ascii_char (rsp.ascii_char),
      .rsp_last_char  (rsp.last_char)
   );

endmodule

// ===== dv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sbdec_pkg::*;

   // Run the block at its full 64-bit width
   localparam int VALUE_WIDTH    = 64;
   localparam int DECIMAL_BASE   = 10;
   localparam int MAX_TEXT_CHARS = 20;

   // Idle odds per side, in percent, and the calm window (by numbers issued)
   // during which neither side idles
   localparam int IDLE_PCT    = 21;
   localparam int CALM_FIRST  = 180;
   localparam int CALM_LAST   = 300;
   localparam int RANDOM_NUMS = 500;
   // Send every DRAIN_EVERY-th random number only after the text of all
   // earlier numbers has come out
   localparam int DRAIN_EVERY = 60;

   // Slowest run: about 520 numbers, each with up to 20 characters of text,
   // under a 21% stalling receiver and a 21% idle sender; take it several
   // times over
   localparam int CYCLE_LIMIT = 400_000;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      logic signed [VALUE_BITS-1:0] value;
      bit                           drain;
   } number_item_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] ascii_char;
      logic                 last_char;
   } text_char_type;

   bit clock;
   bit reset = 1'b1;

   sbdec_req_if req_ch ();
   sbdec_rsp_if rsp_ch ();

   signed_binary_to_decimal_ascii #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   number_item_type pending_numbers[$];
   text_char_type   expected_text[$];

   logic req_taken = 1'b0;
   int   numbers_sent;
   int   numbers_accepted;
   int   negatives_accepted;
   int   chars_checked;
   int   longest_text;
   int   mismatches;
   int   cycle_count;
   logic calm;

   assign calm = (numbers_sent >= CALM_FIRST) && (numbers_sent < CALM_LAST);

   // Free-running clock, 2 ns period
   initial begin
      forever #1 clock = ~clock;
   end

   // Decimal text of one number as the block should send it: sign from bit
   // VALUE_WIDTH-1, magnitude taken unsigned so the most negative value
   // needs no special handling, digits most significant first.
   function automatic void predict_text(input logic [VALUE_BITS-1:0] number);
      logic [VALUE_WIDTH-1:0] word;
      logic [VALUE_WIDTH-1:0] magnitude;
      logic                   negative;
      logic [3:0]             digits[MAX_TEXT_CHARS];
      int                     count;
      int                     chars;
      text_char_type          ch;
      word      = number[VALUE_WIDTH-1:0];
      negative  = word[VALUE_WIDTH-1];
      magnitude = negative ? -word : word;
      count     = 0;
      // Zero still yields one digit, so the do-while covers that case
      do begin
         digits[count] = 4'(magnitude % DECIMAL_BASE);
         magnitude     = magnitude / DECIMAL_BASE;
         count++;
      end while (magnitude != 0);
      chars = count;
      if (negative) begin
         ch.ascii_char = CHAR_MINUS;
         ch.last_char  = 1'b0;
         expected_text.push_back(ch);
         chars++;
      end
      for (int i = count - 1; i >= 0; i--) begin
         ch.ascii_char = CHAR_ZERO + CHAR_BITS'(digits[i]);
         ch.last_char  = (i == 0);
         expected_text.push_back(ch);
      end
      if (chars > longest_text) longest_text = chars;
   endfunction

   function automatic logic [VALUE_BITS-1:0] power_of_ten(input int exponent);
      logic [VALUE_BITS-1:0] p;
      p = 1;
      for (int i = 0; i < exponent; i++) p = p * DECIMAL_BASE;
      return p;
   endfunction

   // Random number shaped to hit every digit count, decade edges and the
   // ends of the range, with plenty of fully random bit patterns as well
   function automatic logic signed [VALUE_BITS-1:0] random_number();
      logic [VALUE_BITS-1:0] n;
      logic [VALUE_BITS-1:0] full;
      bit                    flip;
      full = {$urandom, $urandom};
      flip = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            return full;
         end
         3, 4, 5: begin
            n = full % power_of_ten($urandom_range(1, 19));
         end
         6: begin
            n = power_of_ten($urandom_range(0, 18)) - $urandom_range(0, 1);
         end
         7: begin
            n = $urandom_range(0, 20);
         end
         8: begin
            // Near the most positive or the most negative value
            n    = {1'b0, {(VALUE_BITS-1){1'b1}}} - $urandom_range(0, 15);
            flip = 1'b0;
            if ($urandom_range(0, 1)) n = ~n;
         end
         default: begin
            n = (64'd1 << $urandom_range(0, 62)) + $urandom_range(0, 2) - 1;
         end
      endcase
      return flip ? -n : n;
   endfunction

   task automatic queue_number(input logic signed [VALUE_BITS-1:0] value, input bit drain);
      number_item_type item;
      item.value = value;
      item.drain = drain;
      pending_numbers.push_back(item);
   endtask

   // Driver: update req at the falling edge. Hold valid and value until the
   // transfer happens; a fresh number goes out only when the slot is free.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_numbers.size() != 0
             && !(pending_numbers[0].drain && (expected_text.size() != 0 || req_taken))
             && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_ch.valid <= 1'b1;
            req_ch.value <= pending_numbers[0].value;
            pending_numbers.delete(0);
            numbers_sent++;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: throttle rsp ready at the falling edge
   always @(negedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Predict at the rising edge where a number transfers
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         predict_text(req_ch.value);
         numbers_accepted++;
         if (req_ch.value[VALUE_WIDTH-1]) negatives_accepted++;
      end
   end

   // Monitor: check each character transfer against the oldest expectation
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected character %0d last %0b", $time,
                     rsp_ch.ascii_char, rsp_ch.last_char);
            mismatches++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_ch.ascii_char !== want.ascii_char) begin
               $display("%0t: ascii_char expected %0d got %0d", $time,
                        want.ascii_char, rsp_ch.ascii_char);
               mismatches++;
            end
            if (rsp_ch.last_char !== want.last_char) begin
               $display("%0t: last_char expected %0b got %0b", $time,
                        want.last_char, rsp_ch.last_char);
               mismatches++;
            end
         end
         chars_checked++;
      end
   end

   // Watchdog: drop the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d characters still expected", $time,
                  expected_text.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;

      // Directed: zero, single digits, decade edges, both range ends and
      // their neighbors, alternating bit patterns
      queue_number(64'sd0, 1'b0);
      queue_number(64'sd1, 1'b0);
      queue_number(-64'sd1, 1'b0);
      queue_number(64'sd9, 1'b0);
      queue_number(64'sd10, 1'b0);
      queue_number(-64'sd9, 1'b0);
      queue_number(-64'sd10, 1'b0);
      queue_number(64'sd99, 1'b0);
      queue_number(64'sd100, 1'b0);
      queue_number(64'sh7FFF_FFFF_FFFF_FFFF, 1'b0);
      queue_number(64'sh8000_0000_0000_0000, 1'b0);
      queue_number(64'sh8000_0000_0000_0001, 1'b0);
      queue_number(64'sh7FFF_FFFF_FFFF_FFFE, 1'b0);
      queue_number(64'sd999999999999999999, 1'b0);
      queue_number(64'sd1000000000000000000, 1'b0);
      queue_number(-64'sd1000000000000000000, 1'b0);
      queue_number(64'sh5555_5555_5555_5555, 1'b0);
      queue_number(64'shAAAA_AAAA_AAAA_AAAA, 1'b0);
      queue_number(64'sd12345678901234567, 1'b0);
      queue_number(64'sd4294967295, 1'b0);
      queue_number(-64'sd4294967296, 1'b0);

      // Random: hold off every so often until all earlier text is out
      for (int i = 0; i < RANDOM_NUMS; i++) begin
         queue_number(random_number(), (i % DRAIN_EVERY) == 0);
      end

      // Hold reset, then release it at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every number has transferred, then for the text to drain
      do @(posedge clock); while (pending_numbers.size() != 0 || req_ch.valid);
      do @(posedge clock); while (expected_text.size() != 0);
      // Let any stray character show up
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d numbers (%0d negative) into %0d checked characters,",
               numbers_accepted, negatives_accepted, chars_checked);
      $display("longest text %0d characters, %0d mismatches.", longest_text, mismatches);
      if (mismatches == 0 && expected_text.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
